// File: src/kuct_pkg.sv
// ----------------------------------------------------------------------------
// Keyed usage counter table: shared definitions
// Table sizes, field widths, memory word layouts, sequencer states and the
// counter update function.
// ----------------------------------------------------------------------------
package kuct_pkg;

	localparam int PROVIDER_SLOTS = 16;
	localparam int DAY_SLOTS      = 32;

	localparam int KEY_W  = 64;
	localparam int DATE_W = 27;
	localparam int TOK_W  = 32;
	localparam int CNT_W  = 64;

	localparam int PA_W = (PROVIDER_SLOTS > 1) ? $clog2(PROVIDER_SLOTS) : 1;
	localparam int DA_W = (DAY_SLOTS > 1) ? $clog2(DAY_SLOTS) : 1;
	localparam int PU_W = $clog2(PROVIDER_SLOTS + 1);
	localparam int DU_W = $clog2(DAY_SLOTS + 1);

	localparam int SCAN_LEN = (PROVIDER_SLOTS > DAY_SLOTS) ? PROVIDER_SLOTS : DAY_SLOTS;
	localparam int SC_W     = $clog2(SCAN_LEN + 1);

	typedef struct packed {
		logic [CNT_W-1:0] tin;
		logic [CNT_W-1:0] tout;
		logic [CNT_W-1:0] req;
		logic [CNT_W-1:0] err;
	} cnt_set_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		cnt_set_t         cnt;
	} prov_word_t;

	typedef struct packed {
		logic [DATE_W-1:0] date;
		cnt_set_t          cnt;
	} day_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FETCH,
		ST_UPD
	} state_t;

	function automatic cnt_set_t bump(cnt_set_t c, logic [TOK_W-1:0] tin,
			logic [TOK_W-1:0] tout, logic err);
		cnt_set_t r;
		r.tin  = c.tin + CNT_W'(tin);
		r.tout = c.tout + CNT_W'(tout);
		r.req  = c.req + CNT_W'(1);
		r.err  = c.err + CNT_W'(err);
		return r;
	endfunction

endpackage

// File: src/kuct_if.sv
// ----------------------------------------------------------------------------
// Keyed usage counter table: channel interfaces
// Usage record channel and counter report channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface kuct_usage_if import kuct_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KEY_W-1:0]  provider_key;
	logic [DATE_W-1:0] date_code;
	logic [TOK_W-1:0]  tokens_input;
	logic [TOK_W-1:0]  tokens_output;
	logic              had_error;

	modport source (output valid, provider_key, date_code, tokens_input, tokens_output,
		had_error, input ready);
	modport sink (input valid, provider_key, date_code, tokens_input, tokens_output,
		had_error, output ready);
endinterface

interface kuct_report_if import kuct_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             provider_stored;
	logic [CNT_W-1:0] prov_tokens_in;
	logic [CNT_W-1:0] prov_tokens_out;
	logic [CNT_W-1:0] prov_requests;
	logic [CNT_W-1:0] prov_errors;
	logic [CNT_W-1:0] day_tokens_in;
	logic [CNT_W-1:0] day_tokens_out;
	logic [CNT_W-1:0] day_requests;
	logic [CNT_W-1:0] day_errors;
	logic [CNT_W-1:0] all_tokens;
	logic [CNT_W-1:0] all_requests;
	logic [CNT_W-1:0] all_errors;

	modport source (output valid, provider_stored, prov_tokens_in, prov_tokens_out,
		prov_requests, prov_errors, day_tokens_in, day_tokens_out, day_requests,
		day_errors, all_tokens, all_requests, all_errors, input ready);
	modport sink (input valid, provider_stored, prov_tokens_in, prov_tokens_out,
		prov_requests, prov_errors, day_tokens_in, day_tokens_out, day_requests,
		day_errors, all_tokens, all_requests, all_errors, output ready);
endinterface

// File: src/keyed_usage_counter_table_core.sv
// ----------------------------------------------------------------------------
// Keyed usage counter table core
// Per-provider and per-day usage counters kept in two RAMs, grand totals in registers.
//
//  channel | dir | beat
//  usage   | in  | provider key, date code, token counts, error flag
//  report  | out | provider/day counters after update, grand totals
//
// Each record is handled in turn: both tables are scanned one entry a cycle
// through their RAM read ports, then the hit or new entry is read, bumped
// and written back.
// The day table is a ring; eviction of the oldest day moves the head.
// Reset leaves both tables empty; no clearing pass is needed.
// A new record is taken while the previous report waits; the write-back
// stalls only while an undelivered report still sits in the output register.
// ----------------------------------------------------------------------------
module keyed_usage_counter_table_core import kuct_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	kuct_usage_if.sink     usage,
	kuct_report_if.source  report
);

	state_t state_q, state_d;

	logic [SC_W-1:0] cnt_q;
	logic            pv_s1, dv_s1;
	logic [PA_W-1:0] pidx_s1;
	logic [DA_W-1:0] didx_s1;

	logic            phit_q, dhit_q;
	logic [PA_W-1:0] pidx_q;
	logic [DA_W-1:0] didx_q;

	logic [KEY_W-1:0]  key_q;
	logic [DATE_W-1:0] date_q;
	logic [TOK_W-1:0]  tin_q, tout_q;
	logic              err_q;

	logic [PU_W-1:0] prov_used_q;
	logic [DU_W-1:0] day_used_q;
	logic [DA_W-1:0] day_head_q;

	logic [CNT_W-1:0] tot_tok_q, tot_req_q, tot_err_q;

	logic            pstore_q, pnew_q, dnew_q, devict_q;
	logic [PA_W-1:0] pwaddr_q;
	logic [DA_W-1:0] dwaddr_q;

	logic     rep_valid_q;
	logic     rep_stored_q;
	cnt_set_t rep_prov_q, rep_day_q;
	logic [CNT_W-1:0] rep_tok_q, rep_req_q, rep_err_q;

	prov_word_t prd, pwd;
	day_word_t  drd, dwd;
	logic            p_re, p_we, d_re, d_we;
	logic [PA_W-1:0] p_raddr;
	logic [DA_W-1:0] d_raddr;

	logic     accept, go, scan_more;
	logic     p_iss, d_iss;
	cnt_set_t pnew_cnt, dnew_cnt;

	function automatic logic [DA_W-1:0] ring_add(logic [DA_W-1:0] a, logic [DA_W-1:0] b);
		logic [DA_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (DA_W+1)'(DAY_SLOTS)) begin
			s = s - (DA_W+1)'(DAY_SLOTS);
		end
		return s[DA_W-1:0];
	endfunction

	kuct_ram #(.WIDTH($bits(prov_word_t)), .DEPTH(PROVIDER_SLOTS)) u_prov_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (pwaddr_q),
		.wdata (pwd),
		.re    (p_re),
		.raddr (p_raddr),
		.rdata (prd)
	);

	kuct_ram #(.WIDTH($bits(day_word_t)), .DEPTH(DAY_SLOTS)) u_day_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (dwaddr_q),
		.wdata (dwd),
		.re    (d_re),
		.raddr (d_raddr),
		.rdata (drd)
	);

	assign accept    = usage.valid && usage.ready;
	assign go        = !rep_valid_q || report.ready;
	assign p_iss     = cnt_q < SC_W'(prov_used_q);
	assign d_iss     = cnt_q < SC_W'(day_used_q);
	assign scan_more = (SC_W'(cnt_q + 1'b1) < SC_W'(prov_used_q)) ||
		(SC_W'(cnt_q + 1'b1) < SC_W'(day_used_q));

	assign pnew_cnt = bump(pnew_q ? cnt_set_t'('0) : prd.cnt, tin_q, tout_q, err_q);
	assign dnew_cnt = bump(dnew_q ? cnt_set_t'('0) : drd.cnt, tin_q, tout_q, err_q);
	assign pwd      = '{key: key_q, cnt: pnew_cnt};
	assign dwd      = '{date: date_q, cnt: dnew_cnt};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!scan_more) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_FETCH;
			ST_FETCH: state_d = ST_UPD;
			ST_UPD: begin
				if (go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		usage.ready = 1'b0;
		p_re        = 1'b0;
		d_re        = 1'b0;
		p_raddr     = cnt_q[PA_W-1:0];
		d_raddr     = ring_add(day_head_q, cnt_q[DA_W-1:0]);
		p_we        = 1'b0;
		d_we        = 1'b0;
		case (state_q)
			ST_IDLE: usage.ready = 1'b1;
			ST_SCAN: begin
				p_re = p_iss;
				d_re = d_iss;
			end
			ST_FETCH: begin
				p_re    = phit_q || (prov_used_q < PU_W'(PROVIDER_SLOTS));
				p_raddr = phit_q ? pidx_q : prov_used_q[PA_W-1:0];
				d_re    = 1'b1;
				if (dhit_q) begin
					d_raddr = didx_q;
				end else if (day_used_q < DU_W'(DAY_SLOTS)) begin
					d_raddr = ring_add(day_head_q, day_used_q[DA_W-1:0]);
				end else begin
					d_raddr = day_head_q;
				end
			end
			ST_UPD: begin
				p_we = go && pstore_q;
				d_we = go;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pv_s1       <= 1'b0;
			dv_s1       <= 1'b0;
			phit_q      <= 1'b0;
			dhit_q      <= 1'b0;
			prov_used_q <= '0;
			day_used_q  <= '0;
			day_head_q  <= '0;
			tot_tok_q   <= '0;
			tot_req_q   <= '0;
			tot_err_q   <= '0;
			rep_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pv_s1   <= (state_q == ST_SCAN) && p_iss;
			dv_s1   <= (state_q == ST_SCAN) && d_iss;

			if (accept) begin
				cnt_q  <= '0;
				phit_q <= 1'b0;
				dhit_q <= 1'b0;
			end else begin
				if (state_q == ST_SCAN) begin
					cnt_q <= SC_W'(cnt_q + 1'b1);
				end
				if (pv_s1 && prd.key == key_q) begin
					phit_q <= 1'b1;
				end
				if (dv_s1 && drd.date == date_q) begin
					dhit_q <= 1'b1;
				end
			end

			if (state_q == ST_UPD && go) begin
				if (pstore_q && pnew_q) begin
					prov_used_q <= PU_W'(prov_used_q + 1'b1);
				end
				if (devict_q) begin
					day_head_q <= ring_add(day_head_q, DA_W'(1));
				end else if (dnew_q) begin
					day_used_q <= DU_W'(day_used_q + 1'b1);
				end
				tot_tok_q <= tot_tok_q + CNT_W'(tin_q) + CNT_W'(tout_q);
				tot_req_q <= tot_req_q + CNT_W'(1);
				tot_err_q <= tot_err_q + CNT_W'(err_q);
			end

			if (state_q == ST_UPD && go) begin
				rep_valid_q <= 1'b1;
			end else if (report.ready) begin
				rep_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pidx_s1 <= cnt_q[PA_W-1:0];
		didx_s1 <= d_raddr;
		if (pv_s1 && prd.key == key_q) begin
			pidx_q <= pidx_s1;
		end
		if (dv_s1 && drd.date == date_q) begin
			didx_q <= didx_s1;
		end
		if (accept) begin
			key_q  <= usage.provider_key;
			date_q <= usage.date_code;
			tin_q  <= usage.tokens_input;
			tout_q <= usage.tokens_output;
			err_q  <= usage.had_error;
		end
		if (state_q == ST_FETCH) begin
			pstore_q <= p_re;
			pnew_q   <= !phit_q;
			pwaddr_q <= p_raddr;
			dnew_q   <= !dhit_q;
			devict_q <= !dhit_q && (day_used_q >= DU_W'(DAY_SLOTS));
			dwaddr_q <= d_raddr;
		end
		if (state_q == ST_UPD && go) begin
			rep_stored_q <= pstore_q;
			rep_prov_q   <= pstore_q ? pnew_cnt : cnt_set_t'('0);
			rep_day_q    <= dnew_cnt;
			rep_tok_q    <= tot_tok_q + CNT_W'(tin_q) + CNT_W'(tout_q);
			rep_req_q    <= tot_req_q + CNT_W'(1);
			rep_err_q    <= tot_err_q + CNT_W'(err_q);
		end
	end

	assign report.valid           = rep_valid_q;
	assign report.provider_stored = rep_stored_q;
	assign report.prov_tokens_in  = rep_prov_q.tin;
	assign report.prov_tokens_out = rep_prov_q.tout;
	assign report.prov_requests   = rep_prov_q.req;
	assign report.prov_errors     = rep_prov_q.err;
	assign report.day_tokens_in   = rep_day_q.tin;
	assign report.day_tokens_out  = rep_day_q.tout;
	assign report.day_requests    = rep_day_q.req;
	assign report.day_errors      = rep_day_q.err;
	assign report.all_tokens      = rep_tok_q;
	assign report.all_requests    = rep_req_q;
	assign report.all_errors      = rep_err_q;

	a_prov_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		prov_used_q <= PU_W'(PROVIDER_SLOTS))
		else $error("provider use count above table size");

	a_day_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		day_used_q <= DU_W'(DAY_SLOTS))
		else $error("day use count above table size");

	a_head_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(day_head_q != '0) |-> (day_used_q == DU_W'(DAY_SLOTS)))
		else $error("day ring head moved before table filled");

	a_report_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rep_valid_q) |-> $past(state_q == ST_UPD))
		else $error("report raised outside write-back");

	a_drop_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && go && !pstore_q) |-> (prov_used_q == PU_W'(PROVIDER_SLOTS)))
		else $error("provider update dropped with free slots");

endmodule

// File: src/kuct_ram.sv
// ----------------------------------------------------------------------------
// Keyed usage counter table: simple dual-port RAM
// One write port, one read port, registered read data held while not read.
// ----------------------------------------------------------------------------
module kuct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Keyed usage counter table core: testbench
// Sends usage records through the valid/ready channel and checks every counter
// report against a behavioral model of the provider table, the day table with
// eviction of the oldest day, and the grand totals. Directed records cover the
// field extremes, a full provider table and out-of-calendar dates; random
// records then mix hits, misses and evictions under varying back-pressure.
// ----------------------------------------------------------------------------
module testbench import kuct_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic [KEY_W-1:0]  provider_key;
		logic [DATE_W-1:0] date_code;
		logic [TOK_W-1:0]  tokens_input;
		logic [TOK_W-1:0]  tokens_output;
		logic              had_error;
	} usage_rec_t;

	typedef struct packed {
		logic             provider_stored;
		logic [CNT_W-1:0] prov_tokens_in;
		logic [CNT_W-1:0] prov_tokens_out;
		logic [CNT_W-1:0] prov_requests;
		logic [CNT_W-1:0] prov_errors;
		logic [CNT_W-1:0] day_tokens_in;
		logic [CNT_W-1:0] day_tokens_out;
		logic [CNT_W-1:0] day_requests;
		logic [CNT_W-1:0] day_errors;
		logic [CNT_W-1:0] all_tokens;
		logic [CNT_W-1:0] all_requests;
		logic [CNT_W-1:0] all_errors;
	} report_rec_t;

	class usage_ledger;
		logic [KEY_W-1:0]  prov_key [PROVIDER_SLOTS];
		cnt_set_t          prov_cnt [PROVIDER_SLOTS];
		int                prov_count;
		logic [DATE_W-1:0] day_date [DAY_SLOTS];
		cnt_set_t          day_cnt [DAY_SLOTS];
		int                dates_used;
		cnt_set_t          totals;
		report_rec_t       due_reports [$];
		int                mismatches;
		int                reports;

		function new();
			prov_count = 0;
			dates_used = 0;
			totals     = '0;
			mismatches = 0;
			reports    = 0;
		endfunction

		function cnt_set_t tally(cnt_set_t c, usage_rec_t u);
			cnt_set_t r;
			r.tin  = c.tin + {32'h0, u.tokens_input};
			r.tout = c.tout + {32'h0, u.tokens_output};
			r.req  = c.req + 64'd1;
			r.err  = c.err + {63'h0, u.had_error};
			return r;
		endfunction

		function void record_usage(usage_rec_t u);
			report_rec_t r;
			int p;
			int d;
			r = '0;
			p = -1;
			for (int i = 0; i < prov_count; i++) begin
				if (prov_key[i] == u.provider_key) begin
					p = i;
					break;
				end
			end
			if (p < 0 && prov_count < PROVIDER_SLOTS) begin
				p = prov_count;
				prov_key[p] = u.provider_key;
				prov_cnt[p] = '0;
				prov_count++;
			end
			if (p >= 0) begin
				prov_cnt[p] = tally(prov_cnt[p], u);
				r.provider_stored = 1'b1;
				r.prov_tokens_in  = prov_cnt[p].tin;
				r.prov_tokens_out = prov_cnt[p].tout;
				r.prov_requests   = prov_cnt[p].req;
				r.prov_errors     = prov_cnt[p].err;
			end
			d = -1;
			for (int i = 0; i < dates_used; i++) begin
				if (day_date[i] == u.date_code) begin
					d = i;
					break;
				end
			end
			if (d < 0) begin
				if (dates_used == DAY_SLOTS) begin
					for (int i = 0; i + 1 < DAY_SLOTS; i++) begin
						day_date[i] = day_date[i + 1];
						day_cnt[i]  = day_cnt[i + 1];
					end
					dates_used--;
				end
				d = dates_used;
				day_date[d] = u.date_code;
				day_cnt[d]  = '0;
				dates_used++;
			end
			day_cnt[d] = tally(day_cnt[d], u);
			r.day_tokens_in  = day_cnt[d].tin;
			r.day_tokens_out = day_cnt[d].tout;
			r.day_requests   = day_cnt[d].req;
			r.day_errors     = day_cnt[d].err;
			totals = tally(totals, u);
			r.all_tokens   = totals.tin + totals.tout;
			r.all_requests = totals.req;
			r.all_errors   = totals.err;
			due_reports.push_back(r);
		endfunction

		function void flag(string what, logic [CNT_W-1:0] want, logic [CNT_W-1:0] have);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s at report %0d: expected %h got %h",
					what, reports, want, have);
		endfunction

		function void match_report(report_rec_t have);
			report_rec_t want;
			reports++;
			if (due_reports.size() == 0) begin
				flag("unexpected report, all_requests", '0, have.all_requests);
				return;
			end
			want = due_reports.pop_front();
			if (have.provider_stored !== want.provider_stored)
				flag("provider_stored", CNT_W'(want.provider_stored),
					CNT_W'(have.provider_stored));
			if (have.prov_tokens_in !== want.prov_tokens_in)
				flag("prov_tokens_in", want.prov_tokens_in, have.prov_tokens_in);
			if (have.prov_tokens_out !== want.prov_tokens_out)
				flag("prov_tokens_out", want.prov_tokens_out, have.prov_tokens_out);
			if (have.prov_requests !== want.prov_requests)
				flag("prov_requests", want.prov_requests, have.prov_requests);
			if (have.prov_errors !== want.prov_errors)
				flag("prov_errors", want.prov_errors, have.prov_errors);
			if (have.day_tokens_in !== want.day_tokens_in)
				flag("day_tokens_in", want.day_tokens_in, have.day_tokens_in);
			if (have.day_tokens_out !== want.day_tokens_out)
				flag("day_tokens_out", want.day_tokens_out, have.day_tokens_out);
			if (have.day_requests !== want.day_requests)
				flag("day_requests", want.day_requests, have.day_requests);
			if (have.day_errors !== want.day_errors)
				flag("day_errors", want.day_errors, have.day_errors);
			if (have.all_tokens !== want.all_tokens)
				flag("all_tokens", want.all_tokens, have.all_tokens);
			if (have.all_requests !== want.all_requests)
				flag("all_requests", want.all_requests, have.all_requests);
			if (have.all_errors !== want.all_errors)
				flag("all_errors", want.all_errors, have.all_errors);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic rx_ready = 1'b0;
	int   tx_idle_pct = 25;
	int   rx_idle_pct = 81;
	int   cycles = 0;
	logic [KEY_W-1:0] outsider_keys [4];
	usage_ledger ledger = new();

	kuct_usage_if  usage_ch ();
	kuct_report_if report_ch ();

	assign report_ch.ready = rx_ready;

	keyed_usage_counter_table_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.usage  (usage_ch),
		.report (report_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("keyed_usage_counter_table_core test failed");
			$finish;
		end
	end

	// report side: check each beat, then pick ready for the next edge
	always @(posedge clk) begin
		report_rec_t seen;
		if (arst_n && report_ch.valid && rx_ready) begin
			seen.provider_stored = report_ch.provider_stored;
			seen.prov_tokens_in  = report_ch.prov_tokens_in;
			seen.prov_tokens_out = report_ch.prov_tokens_out;
			seen.prov_requests   = report_ch.prov_requests;
			seen.prov_errors     = report_ch.prov_errors;
			seen.day_tokens_in   = report_ch.day_tokens_in;
			seen.day_tokens_out  = report_ch.day_tokens_out;
			seen.day_requests    = report_ch.day_requests;
			seen.day_errors      = report_ch.day_errors;
			seen.all_tokens      = report_ch.all_tokens;
			seen.all_requests    = report_ch.all_requests;
			seen.all_errors      = report_ch.all_errors;
			ledger.match_report(seen);
		end
		rx_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	task automatic send_record(usage_rec_t u);
		while ($urandom_range(99) < tx_idle_pct) begin
			usage_ch.valid <= 1'b0;
			@(posedge clk);
		end
		usage_ch.valid         <= 1'b1;
		usage_ch.provider_key  <= u.provider_key;
		usage_ch.date_code     <= u.date_code;
		usage_ch.tokens_input  <= u.tokens_input;
		usage_ch.tokens_output <= u.tokens_output;
		usage_ch.had_error     <= u.had_error;
		@(posedge clk);
		while (!usage_ch.ready) @(posedge clk);
		ledger.record_usage(u);
	endtask

	task automatic wait_reports_done();
		usage_ch.valid <= 1'b0;
		@(posedge clk);
		while (ledger.due_reports.size() != 0) @(posedge clk);
	endtask

	function automatic logic [TOK_W-1:0] pick_tokens();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0) return '0;
		if (sel == 1) return '1;
		return $urandom;
	endfunction

	function automatic usage_rec_t make_record();
		usage_rec_t u;
		int sel;
		sel = $urandom_range(99);
		if (sel < 70 && ledger.prov_count > 0)
			u.provider_key = ledger.prov_key[$urandom_range(ledger.prov_count - 1)];
		else if (sel < 80)
			u.provider_key = outsider_keys[$urandom_range(3)];
		else
			u.provider_key = {$urandom, $urandom};
		sel = $urandom_range(99);
		if (sel < 45 && ledger.dates_used > 0)
			u.date_code = ledger.day_date[$urandom_range(ledger.dates_used - 1)];
		else if (sel < 55 && ledger.dates_used > 0)
			u.date_code = ledger.day_date[0];
		else if (sel < 80)
			u.date_code = DATE_W'($urandom_range(2099, 2000) * 10000
				+ $urandom_range(12, 1) * 100 + $urandom_range(31, 1));
		else
			u.date_code = DATE_W'($urandom_range(99991231, 0));
		u.tokens_input  = pick_tokens();
		u.tokens_output = pick_tokens();
		u.had_error     = ($urandom_range(3) == 0);
		return u;
	endfunction

	initial begin
		usage_ch.valid         <= 1'b0;
		usage_ch.provider_key  <= '0;
		usage_ch.date_code     <= '0;
		usage_ch.tokens_input  <= '0;
		usage_ch.tokens_output <= '0;
		usage_ch.had_error     <= 1'b0;
		arst_n <= 1'b0;
		for (int i = 0; i < 4; i++) outsider_keys[i] = {$urandom, $urandom};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, repeat hits, out-of-calendar date
		send_record(usage_rec_t'{64'h0, 27'd0, 32'h0, 32'h0, 1'b0});
		send_record(usage_rec_t'{'1, 27'd99991231, '1, '1, 1'b1});
		send_record(usage_rec_t'{64'h0, 27'd0, '1, 32'h0, 1'b1});
		send_record(usage_rec_t'{64'h5555_5555_5555_5555, 27'd20240229, 32'h0, '1, 1'b0});
		send_record(usage_rec_t'{64'hAAAA_AAAA_AAAA_AAAA, 27'd20241399,
			32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1});
		// fill the provider table
		for (int i = 0; i < 12; i++)
			send_record(usage_rec_t'{64'h0123_4567_89AB_CDEF ^ (64'(i + 1) << 56),
				DATE_W'(20230101 + i * 100), TOK_W'(i * 1000), TOK_W'(i), 1'(i % 2)});
		// table full: dropped, then an existing key still hits
		send_record(usage_rec_t'{64'hDEAD_BEEF_0000_0001, 27'd0, '1, '1, 1'b1});
		send_record(usage_rec_t'{'1, 27'd99991231, 32'h1, 32'h2, 1'b0});

		for (int i = 0; i < 640; i++) send_record(make_record());
		wait_reports_done();

		tx_idle_pct = 81;
		rx_idle_pct = 25;
		for (int i = 0; i < 640; i++) send_record(make_record());
		wait_reports_done();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (int i = 0; i < 620; i++) send_record(make_record());
		wait_reports_done();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (ledger.mismatches == 0 && ledger.due_reports.size() == 0)
			$display("keyed_usage_counter_table_core test passed");
		else
			$display("keyed_usage_counter_table_core test failed");
		$finish;
	end

endmodule
